// File: rtl/core/ipv4_dotted_quad_parser_assert.svh
// assertion macros shared by the parser rtl
`ifndef IPV4_DOTTED_QUAD_PARSER_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSER_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// next-cycle implication, checked only out of reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

// File: rtl/core/ipv4dq_pkg.sv
// types and constants for the dotted quad parser
package ipv4dq_pkg;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [9:0] OCTET_MAX = 10'd255;
    localparam logic [1:0] LAST_PART = 2'd3;
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } item_t;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
    } result_t;

endpackage

// File: rtl/core/ipv4dq_core.sv
// parse state registers and per-character update
`include "ipv4_dotted_quad_parser_assert.svh"

module ipv4dq_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ipv4dq_pkg::item_t item,
    output ipv4dq_pkg::result_t result
);

    logic [1:0]  part_index_reg, part_index_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [9:0]  part_value_reg, part_value_next;
    logic        lead_zero_reg, lead_zero_next;
    logic [23:0] prefix_reg, prefix_next;
    logic        error_reg, error_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [9:0]  value_times_ten;
    logic        ok;

    assign is_digit = (item.char_code >= ipv4dq_pkg::CH_ZERO)
                   && (item.char_code <= ipv4dq_pkg::CH_NINE);
    assign digit = 4'(item.char_code - ipv4dq_pkg::CH_ZERO);
    // x*10 as two shifts and an add
    assign value_times_ten = {part_value_reg[6:0], 3'b000} + {part_value_reg[8:0], 1'b0};

    // end-of-string verdict from the current state
    assign ok = !error_reg && (part_index_reg == ipv4dq_pkg::LAST_PART)
             && (digit_count_reg != 2'd0) && (part_value_reg <= ipv4dq_pkg::OCTET_MAX);
    assign result.valid_res = ok;
    assign result.address   = ok ? {prefix_reg, part_value_reg[7:0]} : 32'd0;

    always_comb
    begin
        part_index_next  = part_index_reg;
        digit_count_next = digit_count_reg;
        part_value_next  = part_value_reg;
        lead_zero_next   = lead_zero_reg;
        prefix_next      = prefix_reg;
        error_next       = error_reg;
        if (item.is_end)
        begin
            part_index_next  = 2'd0;
            digit_count_next = 2'd0;
            part_value_next  = 10'd0;
            lead_zero_next   = 1'b0;
            prefix_next      = 24'd0;
            error_next       = 1'b0;
        end
        else if (!error_reg)
        begin
            if (is_digit)
            begin
                if ((digit_count_reg == ipv4dq_pkg::MAX_DIGITS)
                    || ((digit_count_reg != 2'd0) && lead_zero_reg))
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    if ((digit_count_reg == 2'd0) && (digit == 4'd0))
                    begin
                        lead_zero_next = 1'b1;
                    end
                    part_value_next  = value_times_ten + {6'd0, digit};
                    digit_count_next = digit_count_reg + 2'd1;
                end
            end
            else if (item.char_code == ipv4dq_pkg::CH_DOT)
            begin
                if ((digit_count_reg == 2'd0) || (part_value_reg > ipv4dq_pkg::OCTET_MAX)
                    || (part_index_reg == ipv4dq_pkg::LAST_PART))
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    prefix_next      = {prefix_reg[15:0], part_value_reg[7:0]};
                    part_index_next  = part_index_reg + 2'd1;
                    digit_count_next = 2'd0;
                    part_value_next  = 10'd0;
                    lead_zero_next   = 1'b0;
                end
            end
            else
            begin
                error_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_index_reg  <= 2'd0;
            digit_count_reg <= 2'd0;
            part_value_reg  <= 10'd0;
            lead_zero_reg   <= 1'b0;
            prefix_reg      <= 24'd0;
            error_reg       <= 1'b0;
        end
        else if (step)
        begin
            part_index_reg  <= part_index_next;
            digit_count_reg <= digit_count_next;
            part_value_reg  <= part_value_next;
            lead_zero_reg   <= lead_zero_next;
            prefix_reg      <= prefix_next;
            error_reg       <= error_next;
        end
    end

    // a full three-digit part without a leading zero is at least one hundred
    `DQ_ASSERT_NOW(a_three_digits_big, clk, rst_n,
        (digit_count_reg == ipv4dq_pkg::MAX_DIGITS), (part_value_reg >= 10'd100))
    // a leading zero part never grows past one digit
    `DQ_ASSERT_NOW(a_lead_zero_single, clk, rst_n,
        lead_zero_reg, (digit_count_reg == 2'd1) && (part_value_reg == 10'd0))
    // end marker returns the parser to its starting state
    `DQ_ASSERT_NEXT(a_end_clears, clk, rst_n, step && item.is_end,
        (part_index_reg == 2'd0) && (digit_count_reg == 2'd0) && !error_reg
        && (prefix_reg == 24'd0))

endmodule

// File: rtl/core/ipv4_dotted_quad_parser.sv
// top level of the strict dotted-decimal ipv4 parser
//
// input channel: one string byte per transfer on char_code, closed by a
// transfer with is_end high (char_code ignored then). a transfer happens at
// a rising clk edge with in_valid high and in_stall low.
// output channel: one transfer per end marker, carrying valid_res and
// address (first octet in bits 31:24, zero when the string is not valid).
// the receiver holds out_stall high to keep the result waiting.
// throughput: one character per cycle while no end marker waits for the result
// slot, set by the state update between the input register and the result register.
// after the end marker transfer, the verdict passes the input register and then
// the result register before out_valid rises.
// when the receiver stalls, characters keep flowing; only an end marker
// waits in the input register while the previous result is still pending,
// and in_stall rises for that time.
// reset (rst_n low, asynchronous) empties both registers and clears the
// parse state, so the next byte starts a new string.
`include "ipv4_dotted_quad_parser_assert.svh"

module ipv4_dotted_quad_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [31:0] address
);

    // input register
    logic                in_valid_reg;
    ipv4dq_pkg::item_t   in_item_reg;

    // result register
    logic                out_valid_reg;
    ipv4dq_pkg::result_t out_res_reg;

    ipv4dq_pkg::result_t core_res;
    logic                out_free;
    logic                step;
    logic                take_in;

    // result slot is usable if empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // characters always step; an end marker needs room for its result
    assign step     = in_valid_reg && (!in_item_reg.is_end || out_free);
    assign in_stall = in_valid_reg && !step;
    assign take_in  = in_valid && !in_stall;

    ipv4dq_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && in_item_reg.is_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.char_code <= char_code;
            in_item_reg.is_end    <= is_end;
        end
        if (step && in_item_reg.is_end)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = out_res_reg.valid_res;
    assign address   = out_res_reg.address;

    // a pending end marker with a blocked result slot must hold the input
    `DQ_ASSERT_NOW(a_end_waits, clk, rst_n,
        in_valid_reg && in_item_reg.is_end && out_valid_reg && out_stall, in_stall)
    // a character never blocks the input channel
    `DQ_ASSERT_NOW(a_char_flows, clk, rst_n, in_valid_reg && !in_item_reg.is_end, !in_stall)
    // a finished end marker always lands in the result register
    `DQ_ASSERT_NEXT(a_result_lands, clk, rst_n, step && in_item_reg.is_end, out_valid_reg)

endmodule

// File: tb/testbench.sv
// self-checking testbench for the dotted quad parser
`timescale 1ns / 100ps

module testbench;

    // run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 960;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // kinds of damage done to a generated quad
    typedef enum int {
        TWEAK_NONE,
        TWEAK_LEAD_ZERO,
        TWEAK_BIG_PART,
        TWEAK_LONG_PART,
        TWEAK_BAD_BYTE,
        TWEAK_MISSING_PART,
        TWEAK_EXTRA_PART,
        TWEAK_EMPTY_PART,
        TWEAK_TRAILING_DOT,
        TWEAK_NOISE
    } tweak_t;

    // shadow copy of the parse state
    typedef struct packed {
        logic [1:0]  part_idx;
        logic [1:0]  ndigits;
        logic [9:0]  value;
        logic        lead_zero;
        logic [23:0] prefix;
        logic        bad;
    } parse_state_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        is_end    = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;
    logic [31:0] address;

    parse_state_t        shadow;
    ipv4dq_pkg::result_t pending_quads[$];
    logic [7:0]          text_buf[$];

    int  items_sent     = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    // pacing knobs for the sender and the receiver
    bit  src_jitter     = 1'b0;
    bit  sink_jitter    = 1'b0;
    bit  hold_req       = 1'b0;

    ipv4_dotted_quad_parser u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_end    (is_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res),
        .address   (address)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // gap length: mostly short, sometimes medium, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // advance the shadow parser by one accepted transfer; an end marker
    // yields the expected result and returns the parser to its start
    task automatic follow_char(input logic [7:0] c, input logic e);
        ipv4dq_pkg::result_t r;
        logic                ok;
        if (e)
        begin
            ok = !shadow.bad && shadow.part_idx == ipv4dq_pkg::LAST_PART &&
                 shadow.ndigits != 2'd0 && shadow.value <= ipv4dq_pkg::OCTET_MAX;
            r.valid_res = ok;
            r.address   = ok ? {shadow.prefix, shadow.value[7:0]} : 32'd0;
            pending_quads = {pending_quads, r};
            shadow = '0;
        end
        else if (!shadow.bad)
        begin
            if (c >= ipv4dq_pkg::CH_ZERO && c <= ipv4dq_pkg::CH_NINE)
            begin
                // fourth digit, or any digit after a leading zero
                if (shadow.ndigits >= ipv4dq_pkg::MAX_DIGITS ||
                    (shadow.ndigits != 2'd0 && shadow.lead_zero))
                    shadow.bad = 1'b1;
                else
                begin
                    if (shadow.ndigits == 2'd0 && c == ipv4dq_pkg::CH_ZERO)
                        shadow.lead_zero = 1'b1;
                    shadow.value   = 10'(shadow.value * 10 + (c - ipv4dq_pkg::CH_ZERO));
                    shadow.ndigits = shadow.ndigits + 2'd1;
                end
            end
            else if (c == ipv4dq_pkg::CH_DOT)
            begin
                // empty part, part above 255, or a fifth part starting
                if (shadow.ndigits == 2'd0 || shadow.value > ipv4dq_pkg::OCTET_MAX ||
                    shadow.part_idx >= ipv4dq_pkg::LAST_PART)
                    shadow.bad = 1'b1;
                else
                begin
                    shadow.prefix    = {shadow.prefix[15:0], shadow.value[7:0]};
                    shadow.part_idx  = shadow.part_idx + 2'd1;
                    shadow.ndigits   = 2'd0;
                    shadow.value     = 10'd0;
                    shadow.lead_zero = 1'b0;
                end
            end
            else
                shadow.bad = 1'b1;
        end
    endtask

    // one input transfer, with an optional idle gap in front of it
    task automatic send_item(input logic [7:0] c, input logic e);
        int gap;
        if (src_jitter && $urandom_range(0, 99) < 25)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_end    <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        follow_char(c, e);
        items_sent++;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf = {text_buf, 8'(s.getc(i))};
    endtask

    // send the buffered bytes, then the end marker with a junk byte on it
    task automatic send_text();
        foreach (text_buf[i])
            send_item(text_buf[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        text_buf.delete();
    endtask

    task automatic send_str(input string s);
        put_str(s);
        send_text();
    endtask

    // release the input and wait until every expected result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_quads.size() != 0)
            @(posedge clk);
    endtask

    function automatic string octet_text();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $sformatf("%0d", $urandom_range(0, 9));
        else if (r < 4)
            return $sformatf("%0d", $urandom_range(250, 255));
        else
            return $sformatf("%0d", $urandom_range(0, 255));
    endfunction

    function automatic tweak_t pick_tweak();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return TWEAK_NONE;
        else if (r < 61) return TWEAK_LEAD_ZERO;
        else if (r < 66) return TWEAK_BIG_PART;
        else if (r < 70) return TWEAK_LONG_PART;
        else if (r < 78) return TWEAK_BAD_BYTE;
        else if (r < 83) return TWEAK_MISSING_PART;
        else if (r < 87) return TWEAK_EXTRA_PART;
        else if (r < 91) return TWEAK_EMPTY_PART;
        else if (r < 94) return TWEAK_TRAILING_DOT;
        else             return TWEAK_NOISE;
    endfunction

    // fill text_buf with a quad, most of them well formed
    task automatic build_quad();
        string  part[5];
        int     nparts;
        int     k;
        int     len;
        tweak_t t;
        nparts = 4;
        for (k = 0; k < 5; k++)
            part[k] = octet_text();
        t = pick_tweak();
        k = $urandom_range(0, 3);
        case (t)
            TWEAK_LEAD_ZERO:    part[k] = {"0", part[k]};
            TWEAK_BIG_PART:     part[k] = $sformatf("%0d", $urandom_range(256, 999));
            TWEAK_LONG_PART:    part[k] = $sformatf("%0d", $urandom_range(1000, 99999));
            TWEAK_MISSING_PART: nparts = $urandom_range(1, 3);
            TWEAK_EXTRA_PART:   nparts = 5;
            TWEAK_EMPTY_PART:   part[k] = "";
            default: ;
        endcase
        if (t == TWEAK_NOISE)
        begin
            // arbitrary bytes, including nul and the top half
            len = $urandom_range(0, 12);
            for (k = 0; k < len; k++)
                text_buf = {text_buf, 8'($urandom_range(0, 255))};
        end
        else
        begin
            put_str(part[0]);
            for (k = 1; k < nparts; k++)
            begin
                text_buf = {text_buf, ipv4dq_pkg::CH_DOT};
                put_str(part[k]);
            end
            if (t == TWEAK_TRAILING_DOT)
                text_buf = {text_buf, ipv4dq_pkg::CH_DOT};
            if (t == TWEAK_BAD_BYTE && text_buf.size() != 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // extremes and every error path at least once
    task automatic test_directed();
        send_str("0.0.0.0");
        send_str("255.255.255.255");
        send_str("10.200.3.49");
        send_str("01.2.3.4");
        send_str("1.2.3.00");
        send_str("1234.5.6.7");
        send_str("256.1.1.1");
        send_str("1.2.3.999");
        send_str("1..2.3");
        send_str(".1.2.3");
        send_str("1.2.3.4.5");
        send_str("1.2.3");
        send_str("1.2.3.");
        send_str("");
        send_str("1.2.3.4a");
        // bytes just around the digit range and the dot
        send_str("1.2/.3.4");
        send_str("1.2:.3.4");
        send_str("1-2.3.4");
        // nul and the top byte
        put_str("9.8.");
        text_buf = {text_buf, 8'h00};
        put_str("7.6");
        send_text();
        put_str("9.8.7.");
        text_buf = {text_buf, 8'hFF};
        send_text();
        wait_drained();
    endtask

    // receiver holds off long enough that an end marker backs up and
    // the input side stalls while the sender keeps offering transfers
    task automatic test_backpressure();
        src_jitter = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            build_quad();
            send_text();
        end
        while (hold_req)
            @(posedge clk);
        wait_drained();
    endtask

    // random quads with random pacing, mode switched every few dozen strings
    task automatic test_random_strings();
        int target;
        int n;
        int mode;
        target = items_sent + RANDOM_ITEMS;
        n = 0;
        while (items_sent < target)
        begin
            if (n % 40 == 0)
            begin
                mode = $urandom_range(0, 5);
                src_jitter  = (mode != 0 && mode != 2);
                sink_jitter = (mode != 0 && mode != 3);
            end
            build_quad();
            send_text();
            n++;
        end
        wait_drained();
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    // result checker: compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        ipv4dq_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_quads.size() == 0)
                flag_mismatch($sformatf("unexpected result valid_res=%0b address=%08h",
                                        valid_res, address));
            else
            begin
                want = pending_quads.pop_front();
                if (valid_res !== want.valid_res)
                    flag_mismatch($sformatf("valid_res expected %0b got %0b",
                                            want.valid_res, valid_res));
                if (address !== want.address)
                    flag_mismatch($sformatf("address expected %08h got %08h",
                                            want.address, address));
            end
        end
    end

    // receiver pacing: the long hold-off on request, else random stalls
    initial
    begin : sink_pace
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                n = 0;
                while (n < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    n++;
                end
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (sink_jitter && $urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ipv4_dotted_quad_parser");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        shadow = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        test_directed();
        test_backpressure();
        test_random_strings();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS ipv4_dotted_quad_parser");
        else
            $display("FAIL ipv4_dotted_quad_parser");
        $finish;
    end

endmodule
